// ===== sv/acpc_pkg.sv =====
`timescale 1ns / 1ps

package acpc_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_METHOD          = 3'd0,
		REG_TARGET_COLOR    = 3'd1,
		REG_LUMA_THRESHOLDS = 3'd2,
		REG_DIFF_THRESHOLDS = 3'd3,
		REG_WHITE_THRESHOLD = 3'd4,
		REG_HSV_RED_BOUNDS  = 3'd5,
		REG_HSV_BLUE_BOUNDS = 3'd6
	} cfg_idx_t;

	// Method and target codes
	localparam logic METHOD_BGR = 1'b0;
	localparam logic METHOD_HSV = 1'b1;

	localparam logic [1:0] TGT_DETECT_BLUE = 2'd0;
	localparam logic [1:0] TGT_DETECT_RED  = 2'd1;
	localparam logic [1:0] TGT_DETECT_BOTH = 2'd2;

	// Luma weights, 14-bit fixed point
	localparam int LUMA_W     = 22;
	localparam int LUMA_SHIFT = 14;
	localparam int LUMA_WR    = 4899;
	localparam int LUMA_WG    = 9617;
	localparam int LUMA_WB    = 1868;
	localparam int LUMA_RND   = 8192;

	// Reciprocal tables
	localparam int ROM_DEPTH = 256;
	localparam int SDIV_W    = 20;
	localparam int HDIV_W    = 18;
	localparam int SDIV_NUM  = 255 * 4096;
	localparam int HDIV_NUM  = 256 * 4096;
	localparam int HSV_RND   = 2048;

	localparam int NUM_W   = 12;
	localparam int SPROD_W = 8 + SDIV_W;
	localparam int HPROD_W = NUM_W + HDIV_W + 1;

	typedef struct packed {
		logic        method;
		logic [1:0]  target_color;
		logic [15:0] luma_thresholds;
		logic [23:0] diff_thresholds;
		logic [7:0]  white_threshold;
		logic [47:0] hsv_red_bounds;
		logic [47:0] hsv_blue_bounds;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		method:          METHOD_BGR,
		target_color:    TGT_DETECT_BOTH,
		luma_thresholds: 16'd0,
		diff_thresholds: 24'd0,
		white_threshold: 8'd255,
		hsv_red_bounds:  48'd0,
		hsv_blue_bounds: 48'd0
	};

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pix_t;

	typedef struct packed {
		logic [7:0]              v;
		logic [7:0]              d;
		logic signed [NUM_W-1:0] num;
		logic [7:0]              luma;
		logic                    hue_bgr;
		logic                    green_bgr;
	} s2_t;

	typedef struct packed {
		logic [7:0]              v;
		logic [7:0]              d;
		logic signed [NUM_W-1:0] num;
		logic [SDIV_W-1:0]       sdiv;
		logic [HDIV_W-1:0]       hdiv;
		logic [7:0]              luma;
		logic                    hue_bgr;
		logic                    green_bgr;
	} s3_t;

	typedef struct packed {
		logic [7:0]                v;
		logic [SPROD_W-1:0]        sprod;
		logic signed [HPROD_W-1:0] hprod;
		logic [7:0]                luma;
		logic                      hue_bgr;
		logic                      green_bgr;
	} s4_t;

	typedef struct packed {
		logic luma;
		logic hue;
		logic green;
		logic not_white;
		logic fused;
	} result_t;

	function automatic logic want_red(input logic [1:0] tc);
		return tc != TGT_DETECT_BLUE;
	endfunction

	function automatic logic want_blue(input logic [1:0] tc);
		return tc != TGT_DETECT_RED;
	endfunction

	function automatic logic [7:0] sat_sub(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? (a - b) : 8'd0;
	endfunction

	function automatic logic in_bounds(input logic [47:0] bnd, input logic [7:0] h,
			input logic [7:0] s, input logic [7:0] v);
		return h >= bnd[7:0] && h <= bnd[15:8] &&
			s >= bnd[23:16] && s <= bnd[31:24] &&
			v >= bnd[39:32] && v <= bnd[47:40];
	endfunction

endpackage

// ===== sv/acpc_if.sv =====
`timescale 1ns / 1ps

interface acpc_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_blue;
	logic [7:0] pixel_green;
	logic [7:0] pixel_red;

	modport source (output valid, pixel_blue, pixel_green, pixel_red, input ready);
	modport sink (input valid, pixel_blue, pixel_green, pixel_red, output ready);
endinterface

interface acpc_res_if;
	logic valid;
	logic ready;
	logic luma_mask;
	logic hue_mask;
	logic green_diff_mask;
	logic not_white_mask;
	logic fused_mask;

	modport source (output valid, luma_mask, hue_mask, green_diff_mask, not_white_mask,
		fused_mask, input ready);
	modport sink (input valid, luma_mask, hue_mask, green_diff_mask, not_white_mask,
		fused_mask, output ready);
endinterface

interface acpc_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [acpc_pkg::CFG_IDX_W-1:0]   index;
	logic [acpc_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/armor_color_pixel_classifier.sv =====
`timescale 1ns / 1ps

// Channel      Role    Payload                                        Transaction
// pixel_in     sink    pixel_blue, pixel_green, pixel_red (8b each)   valid && ready
// result_out   source  luma/hue/green_diff/not_white/fused masks      valid && ready
// cfg          sink    index (3b), data (48b), ready always high      valid && ready
//
// One pixel per clock sustained while result_out.ready is held high; five register stages.
// The stages are: input register, luma and max/min, reciprocal table lookup,
// saturation and hue multiply, rounding and mask compare.
// arst_n clears the valid bits and loads the register defaults.
// Each stage takes a new transaction whenever it is empty or its successor
// takes its own, so bubbles close up behind a stalled output.
module armor_color_pixel_classifier (
	input logic        clk,
	input logic        arst_n,
	acpc_pix_if.sink   pixel_in,
	acpc_res_if.source result_out,
	acpc_cfg_if.sink   cfg
);

	acpc_pkg::cfg_t cfg_q;

	logic          valid_2;
	logic          ready_2;
	acpc_pkg::s2_t data_2;
	logic          valid_3;
	logic          ready_3;
	acpc_pkg::s3_t data_3;
	logic          valid_4;
	logic          ready_4;
	acpc_pkg::s4_t data_4;

	assign cfg.ready = 1'b1;

	// Register writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= acpc_pkg::CFG_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (acpc_pkg::cfg_idx_t'(cfg.index))
				acpc_pkg::REG_METHOD:          cfg_q.method          <= cfg.data[0];
				acpc_pkg::REG_TARGET_COLOR:    cfg_q.target_color    <= cfg.data[1:0];
				acpc_pkg::REG_LUMA_THRESHOLDS: cfg_q.luma_thresholds <= cfg.data[15:0];
				acpc_pkg::REG_DIFF_THRESHOLDS: cfg_q.diff_thresholds <= cfg.data[23:0];
				acpc_pkg::REG_WHITE_THRESHOLD: cfg_q.white_threshold <= cfg.data[7:0];
				acpc_pkg::REG_HSV_RED_BOUNDS:  cfg_q.hsv_red_bounds  <= cfg.data[47:0];
				acpc_pkg::REG_HSV_BLUE_BOUNDS: cfg_q.hsv_blue_bounds <= cfg.data[47:0];
				default: ;
			endcase
		end
	end

	acpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pixel_in  (pixel_in),
		.out_valid (valid_2),
		.out_ready (ready_2),
		.out_data  (data_2)
	);

	acpc_recip u_recip (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_2),
		.in_ready  (ready_2),
		.in_data   (data_2),
		.out_valid (valid_3),
		.out_ready (ready_3),
		.out_data  (data_3)
	);

	acpc_hsv_mul u_hsv_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_3),
		.in_ready  (ready_3),
		.in_data   (data_3),
		.out_valid (valid_4),
		.out_ready (ready_4),
		.out_data  (data_4)
	);

	acpc_mask u_mask (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (valid_4),
		.in_ready   (ready_4),
		.in_data    (data_4),
		.result_out (result_out)
	);

endmodule

// ===== sv/acpc_front.sv =====
`timescale 1ns / 1ps

module acpc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  acpc_pkg::cfg_t    cfg,
	acpc_pix_if.sink          pixel_in,
	output logic              out_valid,
	input  logic              out_ready,
	output acpc_pkg::s2_t     out_data
);

	logic                  valid_s1;
	logic                  valid_s2;
	acpc_pkg::pix_t        pix_s1;
	acpc_pkg::s2_t         st_s2;
	logic                  s1_ready;
	logic                  s2_ready;

	logic [7:0]                        mx;
	logic [7:0]                        mn;
	logic [7:0]                        dd;
	logic signed [acpc_pkg::NUM_W-1:0] b12;
	logic signed [acpc_pkg::NUM_W-1:0] g12;
	logic signed [acpc_pkg::NUM_W-1:0] r12;
	logic signed [acpc_pkg::NUM_W-1:0] d12;
	logic signed [acpc_pkg::NUM_W-1:0] num;
	logic [acpc_pkg::LUMA_W-1:0]       luma_sum;
	logic                              wr;
	logic                              wb;
	logic                              hue_bgr;
	logic                              green_bgr;

	// Stage handshake: a stage takes a transaction when empty or draining
	assign s2_ready       = !valid_s2 || out_ready;
	assign s1_ready       = !valid_s1 || s2_ready;
	assign pixel_in.ready = s1_ready;
	assign out_valid      = valid_s2;
	assign out_data       = st_s2;

	// Max, min, hue numerator, luma and channel-difference tests
	always_comb begin
		mx = pix_s1.blue;
		if (pix_s1.green > mx) mx = pix_s1.green;
		if (pix_s1.red > mx) mx = pix_s1.red;
		mn = pix_s1.blue;
		if (pix_s1.green < mn) mn = pix_s1.green;
		if (pix_s1.red < mn) mn = pix_s1.red;
		dd = mx - mn;

		b12 = $signed({4'b0, pix_s1.blue});
		g12 = $signed({4'b0, pix_s1.green});
		r12 = $signed({4'b0, pix_s1.red});
		d12 = $signed({4'b0, dd});
		if (mx == pix_s1.red)
			num = g12 - b12;
		else if (mx == pix_s1.green)
			num = b12 - r12 + (d12 <<< 1);
		else
			num = r12 - g12 + (d12 <<< 2);

		luma_sum = acpc_pkg::LUMA_W'(acpc_pkg::LUMA_WR) * acpc_pkg::LUMA_W'(pix_s1.red)
			+ acpc_pkg::LUMA_W'(acpc_pkg::LUMA_WG) * acpc_pkg::LUMA_W'(pix_s1.green)
			+ acpc_pkg::LUMA_W'(acpc_pkg::LUMA_WB) * acpc_pkg::LUMA_W'(pix_s1.blue)
			+ acpc_pkg::LUMA_W'(acpc_pkg::LUMA_RND);

		wr = acpc_pkg::want_red(cfg.target_color);
		wb = acpc_pkg::want_blue(cfg.target_color);
		hue_bgr =
			(wr && acpc_pkg::sat_sub(pix_s1.red, pix_s1.blue) > cfg.diff_thresholds[7:0]) ||
			(wb && acpc_pkg::sat_sub(pix_s1.blue, pix_s1.red) > cfg.diff_thresholds[15:8]);
		green_bgr =
			(wr && acpc_pkg::sat_sub(pix_s1.red, pix_s1.green) > cfg.diff_thresholds[23:16]) ||
			(wb && acpc_pkg::sat_sub(pix_s1.blue, pix_s1.green) > cfg.diff_thresholds[23:16]);
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_ready) valid_s1 <= pixel_in.valid;
			if (s2_ready) valid_s2 <= valid_s1;
		end
	end

	// Load payload on each accepted transaction
	always_ff @(posedge clk) begin
		if (pixel_in.valid && s1_ready) begin
			pix_s1.blue  <= pixel_in.pixel_blue;
			pix_s1.green <= pixel_in.pixel_green;
			pix_s1.red   <= pixel_in.pixel_red;
		end
		if (valid_s1 && s2_ready) begin
			st_s2.v         <= mx;
			st_s2.d         <= dd;
			st_s2.num       <= num;
			st_s2.luma      <= luma_sum[acpc_pkg::LUMA_W-1:acpc_pkg::LUMA_SHIFT];
			st_s2.hue_bgr   <= hue_bgr;
			st_s2.green_bgr <= green_bgr;
		end
	end

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_in.valid && s1_ready |=> valid_s1)
		else $error("accepted pixel did not reach the first stage");

	a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s2_ready |=> valid_s1 && $stable(pix_s1))
		else $error("first stage lost or changed a stalled pixel");

endmodule

// ===== sv/acpc_recip.sv =====
`timescale 1ns / 1ps

module acpc_recip (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  acpc_pkg::s2_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output acpc_pkg::s3_t  out_data
);

	localparam int SdivW = acpc_pkg::SDIV_W;
	localparam int HdivW = acpc_pkg::HDIV_W;

	logic [SdivW-1:0] sdiv_rom [acpc_pkg::ROM_DEPTH];
	logic [HdivW-1:0] hdiv_rom [acpc_pkg::ROM_DEPTH];

	logic          valid_s3;
	acpc_pkg::s3_t st_s3;

	// Reciprocal tables, rounded to nearest with ties to even; zero maps to zero
	assign sdiv_rom[0] = '0;
	assign hdiv_rom[0] = '0;

	for (genvar K = 1; K < acpc_pkg::ROM_DEPTH; K++) begin : g_rom
		localparam int SdivQ   = acpc_pkg::SDIV_NUM / K;
		localparam int SdivR   = acpc_pkg::SDIV_NUM % K;
		localparam int SdivUp  = (2 * SdivR > K || (2 * SdivR == K && SdivQ % 2 == 1)) ? 1 : 0;
		localparam int HdivDen = 6 * K;
		localparam int HdivQ   = acpc_pkg::HDIV_NUM / HdivDen;
		localparam int HdivR   = acpc_pkg::HDIV_NUM % HdivDen;
		localparam int HdivUp  =
			(2 * HdivR > HdivDen || (2 * HdivR == HdivDen && HdivQ % 2 == 1)) ? 1 : 0;

		assign sdiv_rom[K] = SdivW'(SdivQ + SdivUp);
		assign hdiv_rom[K] = HdivW'(HdivQ + HdivUp);
	end

	assign in_ready  = !valid_s3 || out_ready;
	assign out_valid = valid_s3;
	assign out_data  = st_s3;

	// Advance valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else if (in_ready)
			valid_s3 <= in_valid;
	end

	// Look up both reciprocals
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			st_s3.v         <= in_data.v;
			st_s3.d         <= in_data.d;
			st_s3.num       <= in_data.num;
			st_s3.sdiv      <= sdiv_rom[in_data.v];
			st_s3.hdiv      <= hdiv_rom[in_data.d];
			st_s3.luma      <= in_data.luma;
			st_s3.hue_bgr   <= in_data.hue_bgr;
			st_s3.green_bgr <= in_data.green_bgr;
		end
	end

	a_hdiv_zero_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && st_s3.d == '0 |-> st_s3.hdiv == '0)
		else $error("hue reciprocal nonzero for a gray pixel");

	a_sdiv_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && st_s3.v != '0 |-> st_s3.sdiv != '0)
		else $error("saturation reciprocal zero for a lit pixel");

endmodule

// ===== sv/acpc_hsv_mul.sv =====
`timescale 1ns / 1ps

module acpc_hsv_mul (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  acpc_pkg::s3_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output acpc_pkg::s4_t  out_data
);

	logic                                valid_s4;
	acpc_pkg::s4_t                       st_s4;
	logic [acpc_pkg::SPROD_W-1:0]        sprod;
	logic signed [acpc_pkg::HPROD_W-1:0] hprod;

	assign in_ready  = !valid_s4 || out_ready;
	assign out_valid = valid_s4;
	assign out_data  = st_s4;

	// Saturation and hue products
	always_comb begin
		sprod = acpc_pkg::SPROD_W'(in_data.d) * acpc_pkg::SPROD_W'(in_data.sdiv);
		hprod = $signed(in_data.num) * $signed({1'b0, in_data.hdiv});
	end

	// Advance valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s4 <= 1'b0;
		else if (in_ready)
			valid_s4 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			st_s4.v         <= in_data.v;
			st_s4.sprod     <= sprod;
			st_s4.hprod     <= hprod;
			st_s4.luma      <= in_data.luma;
			st_s4.hue_bgr   <= in_data.hue_bgr;
			st_s4.green_bgr <= in_data.green_bgr;
		end
	end

endmodule

// ===== sv/acpc_mask.sv =====
`timescale 1ns / 1ps

module acpc_mask (
	input  logic            clk,
	input  logic            arst_n,
	input  acpc_pkg::cfg_t  cfg,
	input  logic            in_valid,
	output logic            in_ready,
	input  acpc_pkg::s4_t   in_data,
	acpc_res_if.source      result_out
);

	localparam int SprodW = acpc_pkg::SPROD_W;
	localparam int HsumW  = acpc_pkg::HPROD_W + 1;
	localparam int HvW    = HsumW - 12;

	logic                 valid_s5;
	acpc_pkg::result_t    res_s5;
	acpc_pkg::result_t    res;

	logic [SprodW-1:0]      s_sum;
	logic [7:0]             sat;
	logic signed [HsumW-1:0] h_sum;
	logic signed [HvW-1:0]  hv;
	logic signed [HvW-1:0]  hv_w;
	logic [7:0]             hue;
	logic                   wr;
	logic                   wb;
	logic                   hue_hsv;

	assign in_ready = !valid_s5 || result_out.ready;

	assign result_out.valid           = valid_s5;
	assign result_out.luma_mask       = res_s5.luma;
	assign result_out.hue_mask        = res_s5.hue;
	assign result_out.green_diff_mask = res_s5.green;
	assign result_out.not_white_mask  = res_s5.not_white;
	assign result_out.fused_mask      = res_s5.fused;

	// Round saturation and hue, wrap negative hue, then form the masks
	always_comb begin
		s_sum = in_data.sprod + SprodW'(acpc_pkg::HSV_RND);
		sat   = s_sum[19:12];

		h_sum = {in_data.hprod[acpc_pkg::HPROD_W-1], in_data.hprod}
			+ HsumW'(acpc_pkg::HSV_RND);
		hv    = h_sum[HsumW-1:12];
		hv_w  = hv[HvW-1] ? (hv + HvW'(256)) : hv;
		if (hv_w[HvW-1])
			hue = 8'd0;
		else if (hv_w > HvW'(255))
			hue = 8'd255;
		else
			hue = hv_w[7:0];

		wr = acpc_pkg::want_red(cfg.target_color);
		wb = acpc_pkg::want_blue(cfg.target_color);
		hue_hsv = (wr && acpc_pkg::in_bounds(cfg.hsv_red_bounds, hue, sat, in_data.v)) ||
			(wb && acpc_pkg::in_bounds(cfg.hsv_blue_bounds, hue, sat, in_data.v));

		res.luma = (wr && in_data.luma > cfg.luma_thresholds[7:0]) ||
			(wb && in_data.luma > cfg.luma_thresholds[15:8]);
		res.not_white = in_data.luma <= cfg.white_threshold;
		if (cfg.method == acpc_pkg::METHOD_HSV) begin
			res.hue   = hue_hsv;
			res.green = 1'b0;
			res.fused = res.luma && hue_hsv && res.not_white;
		end else begin
			res.hue   = in_data.hue_bgr;
			res.green = in_data.green_bgr;
			res.fused = res.luma && in_data.hue_bgr && in_data.green_bgr && res.not_white;
		end
	end

	// Advance valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s5 <= 1'b0;
		else if (in_ready)
			valid_s5 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			res_s5 <= res;
	end

	a_fused_implies_masks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 |-> !res_s5.fused || (res_s5.luma && res_s5.hue && res_s5.not_white))
		else $error("fused mask set without its component masks");

endmodule
